// ===== rtl/ecr_pkg.sv =====
// ----------------------------------------------------------------------------
// ecr_pkg: shared types and constants of the elevation color ramp
// Color stops, segment divisors and the channel blend function.
// ----------------------------------------------------------------------------
package ecr_pkg;

    localparam int STOP_COUNT  = 7;
    localparam int ELEV_W      = 21;
    localparam int MASK_W      = 8;
    localparam int DIST_W      = 16;
    localparam int RECIP_W     = 21;
    localparam int AMOUNT_W    = 17;
    localparam int IDX_W       = 3;
    localparam int CFG_IDX_W   = 2;

    localparam logic [AMOUNT_W-1:0] AMOUNT_ONE  = 17'd65536;
    localparam logic [7:0]          VALID_ALPHA = 8'd210;

    // Register indexes of the configuration channel.
    localparam logic [CFG_IDX_W-1:0] CFG_NODATA_ENABLE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NODATA_VALUE  = 2'd1;

    // Stop elevations in metres with four fraction bits.
    localparam logic signed [ELEV_W-1:0] STOP_LEVEL [STOP_COUNT] = '{
        -21'sd8000, 21'sd0, 21'sd3200, 21'sd16000, 21'sd48000, 21'sd96000, 21'sd144000
    };
    localparam logic [7:0] STOP_RED   [STOP_COUNT] = '{38, 72, 98, 201, 145, 244, 255};
    localparam logic [7:0] STOP_GREEN [STOP_COUNT] = '{88, 132, 167, 184, 105, 244, 255};
    localparam logic [7:0] STOP_BLUE  [STOP_COUNT] = '{168, 187, 92, 124, 77, 244, 255};

    // Control that travels alongside one sample down the pipeline.
    typedef struct packed {
        logic             pix_valid;
        logic [IDX_W-1:0] lo;
        logic [IDX_W-1:0] hi;
        logic             zero_amt;
        logic             full_amt;
    } t_side;

    // Span of the segment that ends at stop hi.
    function automatic logic [DIST_W-1:0] seg_width(input logic [IDX_W-1:0] hi);
        logic [DIST_W-1:0] w;
        case (hi)
            3'd1:    w = 16'd8000;
            3'd2:    w = 16'd3200;
            3'd3:    w = 16'd12800;
            3'd4:    w = 16'd32000;
            3'd5:    w = 16'd48000;
            3'd6:    w = 16'd48000;
            default: w = 16'd1;
        endcase
        return w;
    endfunction

    // floor(2^32 / width); the quotient estimate is then low by at most one.
    function automatic logic [RECIP_W-1:0] seg_recip(input logic [IDX_W-1:0] hi);
        logic [RECIP_W-1:0] m;
        case (hi)
            3'd1:    m = 21'd536870;
            3'd2:    m = 21'd1342177;
            3'd3:    m = 21'd335544;
            3'd4:    m = 21'd134217;
            3'd5:    m = 21'd89478;
            3'd6:    m = 21'd89478;
            default: m = 21'd0;
        endcase
        return m;
    endfunction

    // floor((left * 2^16 + (right - left) * amount) / 2^16); never negative.
    function automatic logic [7:0] mix_channel(input logic [7:0]          left,
                                               input logic [7:0]          right,
                                               input logic [AMOUNT_W-1:0] amount);
        logic signed [9:0]  diff;
        logic signed [27:0] prod;
        logic signed [27:0] total;
        diff  = $signed({2'b00, right}) - $signed({2'b00, left});
        prod  = 28'(diff) * 28'($signed({1'b0, amount}));
        total = $signed({4'b0000, left, 16'h0000}) + prod;
        return total[23:16];
    endfunction

endpackage

// ===== rtl/ecr_divide.sv =====
// ----------------------------------------------------------------------------
// ecr_divide: pipelined blend amount divider
// Computes floor(dist * 2^16 / width) by reciprocal multiply and one correction
// step over three register stages, with a ready chain that stalls per stage.
// ----------------------------------------------------------------------------
module ecr_divide
    import ecr_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [DIST_W-1:0]   i_dist,
    input  t_side               i_side,
    output logic                o_valid,
    input  logic                i_ready,
    output logic [AMOUNT_W-1:0] o_amount,
    output t_side               o_side
);

    localparam int PROD_W = DIST_W + RECIP_W;
    localparam int NUM_W  = 2 * DIST_W;

    logic                r_a_v;
    logic [PROD_W-1:0]   r_a_prod;
    logic [DIST_W-1:0]   r_a_dist;
    t_side               r_a_side;

    logic                r_b_v;
    logic [DIST_W-1:0]   r_b_qest;
    logic [NUM_W-1:0]    r_b_qw;
    logic [DIST_W-1:0]   r_b_dist;
    t_side               r_b_side;

    logic                r_c_v;
    logic [AMOUNT_W-1:0] r_c_amount;
    t_side               r_c_side;

    logic                a_en;
    logic                b_en;
    logic                c_en;
    logic [PROD_W-1:0]   n_a_prod;
    logic [DIST_W-1:0]   n_b_qest;
    logic [NUM_W-1:0]    n_b_qw;
    logic [NUM_W-1:0]    rem;
    logic [DIST_W-1:0]   qfix;
    logic [AMOUNT_W-1:0] n_c_amount;

    assign c_en    = !r_c_v || i_ready;
    assign b_en    = !r_b_v || c_en;
    assign a_en    = !r_a_v || b_en;
    assign o_ready = a_en;

    assign n_a_prod = PROD_W'(i_dist) * PROD_W'(seg_recip(i_side.hi));

    // Unflagged samples keep the product below 2^32; the estimate is 16 bits.
    assign n_b_qest = r_a_prod[NUM_W-1:DIST_W];
    assign n_b_qw   = NUM_W'(n_b_qest) * NUM_W'(seg_width(r_a_side.hi));

    always_comb begin
        rem  = {r_b_dist, {DIST_W{1'b0}}} - r_b_qw;
        qfix = r_b_qest;
        if (rem >= NUM_W'(seg_width(r_b_side.hi))) begin
            qfix = r_b_qest + 1'b1;
        end
        if (r_b_side.full_amt) begin
            n_c_amount = AMOUNT_ONE;
        end else if (r_b_side.zero_amt) begin
            n_c_amount = '0;
        end else begin
            n_c_amount = {1'b0, qfix};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
            r_b_v <= 1'b0;
            r_c_v <= 1'b0;
        end else begin
            if (a_en) begin
                r_a_v <= i_valid;
            end
            if (b_en) begin
                r_b_v <= r_a_v;
            end
            if (c_en) begin
                r_c_v <= r_b_v;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_en) begin
            r_a_prod <= n_a_prod;
            r_a_dist <= i_dist;
            r_a_side <= i_side;
        end
        if (b_en) begin
            r_b_qest <= n_b_qest;
            r_b_qw   <= n_b_qw;
            r_b_dist <= r_a_dist;
            r_b_side <= r_a_side;
        end
        if (c_en) begin
            r_c_amount <= n_c_amount;
            r_c_side   <= r_b_side;
        end
    end

    assign o_valid  = r_c_v;
    assign o_amount = r_c_amount;
    assign o_side   = r_c_side;

endmodule

// ===== rtl/elevation_color_ramp_unit.sv =====
// ----------------------------------------------------------------------------
// elevation_color_ramp_unit: hypsometric color ramp for an elevation stream
// Maps each elevation sample to one RGBA pixel by blending between fixed stops.
// ----------------------------------------------------------------------------
// Usage:
//   Samples arrive on the s_axis channel: tdata holds the elevation (Q16.4,
//   signed) and the mask byte, tuser holds the finite flag. Pixels leave on
//   the m_axis channel as red, green, blue and alpha bytes.
//   The configuration channel writes the nodata enable and the nodata value;
//   write it only while no sample is in flight. It is always ready.
//   The pipeline has five register stages: one classify stage, three divider
//   stages (reciprocal multiply, back multiply, correction) and the blend
//   stage that loads the output register.
//   Unstalled throughput is one pixel per clock; every stage has its own valid bit and
//   takes a new sample whenever it is empty or its successor moves.
//   When the receiver stalls, the pixel holds on m_axis and the stages fill
//   up behind it; s_axis_tready drops only once all five stages are full.
//   Reset empties the pipeline and clears both registers to zero.
// ----------------------------------------------------------------------------
module elevation_color_ramp_unit
    import ecr_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [31:0]          s_axis_tdata,  // [20:0] elevation, [28:21] mask_byte
    input  logic                 s_axis_tuser,  // [0] sample_finite
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [31:0]          m_axis_tdata,  // [7:0] red, [15:8] green, [23:16] blue,
                                                // [31:24] alpha
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [ELEV_W-1:0]    i_cfg_data
);

    logic                     r_nodata_en;
    logic signed [ELEV_W-1:0] r_nodata_val;

    logic                     r_s1_v;
    logic [DIST_W-1:0]        r_s1_dist;
    t_side                    r_s1_side;

    logic                     r_out_v;
    logic [31:0]              r_out_data;

    logic signed [ELEV_W-1:0] elev;
    logic [MASK_W-1:0]        mask;
    logic [IDX_W-1:0]         sel_hi;
    logic                     found;
    logic signed [ELEV_W:0]   seg_offset;
    t_side                    n_s1_side;

    logic                     s1_en;
    logic                     out_en;
    logic                     div_ready;
    logic                     div_valid;
    logic [AMOUNT_W-1:0]      div_amount;
    t_side                    div_side;
    logic [31:0]              n_out_data;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nodata_en  <= 1'b0;
            r_nodata_val <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_NODATA_ENABLE: r_nodata_en  <= i_cfg_data[0];
                CFG_NODATA_VALUE:  r_nodata_val <= $signed(i_cfg_data);
                default: ;
            endcase
        end
    end

    // Classify: validity, segment search and distance from the lower stop.
    assign elev = $signed(s_axis_tdata[ELEV_W-1:0]);
    assign mask = s_axis_tdata[ELEV_W+MASK_W-1:ELEV_W];

    always_comb begin
        sel_hi = IDX_W'(STOP_COUNT - 1);
        found  = 1'b0;
        for (int i = STOP_COUNT - 1; i >= 1; i--) begin
            if (elev <= STOP_LEVEL[i]) begin
                sel_hi = IDX_W'(i);
                found  = 1'b1;
            end
        end
        n_s1_side.pix_valid = (mask != '0) && s_axis_tuser &&
                              !(r_nodata_en && (elev == r_nodata_val));
        n_s1_side.hi = sel_hi;
        // Above the top stop the blend runs from the first stop at full amount.
        n_s1_side.lo = found ? sel_hi - 1'b1 : '0;
        seg_offset = (ELEV_W+1)'(elev) - (ELEV_W+1)'(STOP_LEVEL[n_s1_side.lo]);
        n_s1_side.zero_amt = elev <= STOP_LEVEL[n_s1_side.lo];
        n_s1_side.full_amt = elev >= STOP_LEVEL[n_s1_side.hi];
    end

    assign s1_en         = !r_s1_v || div_ready;
    assign s_axis_tready = s1_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
        end else if (s1_en) begin
            r_s1_v <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_en) begin
            r_s1_dist <= seg_offset[DIST_W-1:0];
            r_s1_side <= n_s1_side;
        end
    end

    ecr_divide u_divide (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (r_s1_v),
        .o_ready  (div_ready),
        .i_dist   (r_s1_dist),
        .i_side   (r_s1_side),
        .o_valid  (div_valid),
        .i_ready  (out_en),
        .o_amount (div_amount),
        .o_side   (div_side)
    );

    // Blend stage feeding the output register.
    always_comb begin
        if (div_side.pix_valid) begin
            n_out_data = {VALID_ALPHA,
                          mix_channel(STOP_BLUE[div_side.lo],  STOP_BLUE[div_side.hi],
                                      div_amount),
                          mix_channel(STOP_GREEN[div_side.lo], STOP_GREEN[div_side.hi],
                                      div_amount),
                          mix_channel(STOP_RED[div_side.lo],   STOP_RED[div_side.hi],
                                      div_amount)};
        end else begin
            n_out_data = '0;
        end
    end

    assign out_en = !r_out_v || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (out_en) begin
            r_out_v <= div_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_en) begin
            r_out_data <= n_out_data;
        end
    end

    assign m_axis_tvalid = r_out_v;
    assign m_axis_tdata  = r_out_data;

    // An invalid pixel is all zeros; a valid one carries the fixed alpha.
    a_pixel_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata == 32'h0) || (m_axis_tdata[31:24] == VALID_ALPHA))
        else $error("pixel with inconsistent alpha");

    a_amount_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_valid |-> (div_amount <= AMOUNT_ONE))
        else $error("blend amount out of range");

    a_flags_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_v |-> !(r_s1_side.zero_amt && r_s1_side.full_amt))
        else $error("sample both below and above its segment");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (div_valid && r_out_v && !m_axis_tready) |=> div_valid)
        else $error("divider dropped a sample while the output stalled");

endmodule

// ===== tb/sv/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench: self-checking bench for elevation_color_ramp_unit
// Streams elevation samples through the color ramp while both sides idle at
// random, predicts every RGBA pixel in the bench and compares it with the
// m_axis output. The nodata registers are rewritten between traffic phases.
// ----------------------------------------------------------------------------
module testbench;
    import ecr_pkg::*;

    localparam int STALL_LIMIT = 4000;
    localparam int REPORT_MAX  = 10;
    localparam int RAMP_ONE    = 65536;
    localparam int PIXEL_ALPHA = 210;
    localparam int ELEV_MIN    = -1048576;
    localparam int ELEV_MAX    = 1048575;

    // Writes to these indexes hit no register and must be ignored.
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_3 = 2'd3;

    // Color stops: level in metres with four fraction bits, then RGB.
    localparam int RAMP_LEVEL [7] = '{-8000, 0, 3200, 16000, 48000, 96000, 144000};
    localparam int RAMP_R     [7] = '{38, 72, 98, 201, 145, 244, 255};
    localparam int RAMP_G     [7] = '{88, 132, 167, 184, 105, 244, 255};
    localparam int RAMP_B     [7] = '{168, 187, 92, 124, 77, 244, 255};

    typedef struct packed {
        logic        finite;
        logic [7:0]  mask;
        logic [20:0] elev;
    } t_sample;

    typedef struct packed {
        logic [7:0] alpha;
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } t_pixel;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [31:0]          s_axis_tdata = '0;
    logic                 s_axis_tuser = 1'b0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [31:0]          m_axis_tdata;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [ELEV_W-1:0]    i_cfg_data = '0;

    t_sample sample_q [$];
    t_pixel  pixel_q [$];
    t_sample tx_cur;
    t_pixel  rx_want;
    t_pixel  rx_got;

    bit nodata_on = 1'b0;
    int nodata_elev = 0;

    int tx_wait = 0;
    int tx_calm = 0;
    int rx_wait = 0;
    int rx_calm = 0;
    int idle_cycles = 0;
    int mismatches = 0;
    int samples_sent = 0;
    int pixels_colored = 0;
    int pixels_blank = 0;
    int reg_writes = 0;

    elevation_color_ramp_unit u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic int blend_channel(input int left, input int right, input longint frac);
        longint total;
        total = longint'(left) * RAMP_ONE + longint'(right - left) * frac;
        if (total < 0) total = 0;
        return int'((total >> 16) & 255);
    endfunction

    function automatic t_pixel predict_pixel(input t_sample s);
        t_pixel px;
        int     e;
        int     lo;
        int     hi;
        bit     found;
        longint lower;
        longint upper;
        longint frac;
        px = '0;
        e = $signed(s.elev);
        if (s.mask == 8'd0 || !s.finite || (nodata_on && e == nodata_elev)) return px;
        lo = 0;
        hi = 6;
        found = 1'b0;
        // The first stop at or above the sample closes the segment; none means white.
        for (int i = 1; i < 7; i++) begin
            if (!found && e <= RAMP_LEVEL[i]) begin
                lo = i - 1;
                hi = i;
                found = 1'b1;
            end
        end
        lower = RAMP_LEVEL[lo];
        upper = RAMP_LEVEL[hi];
        if (e <= lower) frac = 0;
        else if (e >= upper) frac = RAMP_ONE;
        else frac = ((longint'(e) - lower) * RAMP_ONE) / (upper - lower);
        px.red   = 8'(blend_channel(RAMP_R[lo], RAMP_R[hi], frac));
        px.green = 8'(blend_channel(RAMP_G[lo], RAMP_G[hi], frac));
        px.blue  = 8'(blend_channel(RAMP_B[lo], RAMP_B[hi], frac));
        px.alpha = 8'(PIXEL_ALPHA);
        return px;
    endfunction

    function automatic int idle_length();
        int r;
        r = $urandom_range(99);
        if (r < 65) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(6, 30);
    endfunction

    // Sample driver.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                pixel_q = {pixel_q, predict_pixel(tx_cur)};
                samples_sent++;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (tx_wait > 0 || sample_q.size() == 0) begin
                    if (tx_wait > 0) tx_wait--;
                    s_axis_tvalid <= 1'b0;
                end else begin
                    tx_cur = sample_q.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= {3'b000, tx_cur.mask, tx_cur.elev};
                    s_axis_tuser  <= tx_cur.finite;
                    if (tx_calm > 0) begin
                        tx_calm--;
                        tx_wait = 0;
                    end else if ($urandom_range(99) < 3) begin
                        tx_calm = $urandom_range(20, 80);
                        tx_wait = 0;
                    end else begin
                        tx_wait = idle_length();
                    end
                end
            end
        end
    end

    // Pixel monitor and receiver backpressure.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                rx_got = m_axis_tdata;
                if (pixel_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= REPORT_MAX)
                        $display("unexpected pixel r=%0d g=%0d b=%0d a=%0d", rx_got.red,
                                 rx_got.green, rx_got.blue, rx_got.alpha);
                end else begin
                    rx_want = pixel_q.pop_front();
                    if (rx_want.alpha != 8'd0) pixels_colored++;
                    else pixels_blank++;
                    if (rx_got.red != rx_want.red || rx_got.green != rx_want.green ||
                        rx_got.blue != rx_want.blue || rx_got.alpha != rx_want.alpha) begin
                        mismatches++;
                        if (mismatches <= REPORT_MAX)
                            $display("mismatch: want %0d,%0d,%0d,%0d got %0d,%0d,%0d,%0d",
                                     rx_want.red, rx_want.green, rx_want.blue, rx_want.alpha,
                                     rx_got.red, rx_got.green, rx_got.blue, rx_got.alpha);
                    end
                end
            end
            if (rx_wait > 0) begin
                rx_wait--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
                if (rx_calm > 0) begin
                    rx_calm--;
                end else if ($urandom_range(99) < 3) begin
                    rx_calm = $urandom_range(20, 80);
                end else begin
                    rx_wait = idle_length();
                end
            end
        end
    end

    // Any transaction on any channel counts as progress.
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (i_cfg_valid && o_cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial begin
        wait (idle_cycles >= STALL_LIMIT);
        $display("timeout: no transaction for %0d cycles", STALL_LIMIT);
        $display("RESULT: ERROR");
        $finish;
    end

    task automatic add_sample(input int e, input int m, input bit f);
        t_sample s;
        s.elev   = e[20:0];
        s.mask   = m[7:0];
        s.finite = f;
        sample_q = {sample_q, s};
    endtask

    task automatic add_random(input int count);
        int          r;
        int          e;
        int          m;
        bit          f;
        logic [20:0] raw;
        for (int n = 0; n < count; n++) begin
            r = $urandom_range(99);
            if (r < 35) begin
                e = int'($urandom_range(160000)) - 9000;
            end else if (r < 55) begin
                e = RAMP_LEVEL[$urandom_range(6)] + int'($urandom_range(8)) - 4;
            end else if (r < 75) begin
                raw = 21'($urandom());
                e = $signed(raw);
            end else if (r < 80) begin
                e = ($urandom_range(1) != 0) ? ELEV_MAX - int'($urandom_range(2))
                                             : ELEV_MIN + int'($urandom_range(2));
            end else if (r < 90) begin
                e = nodata_elev;
            end else begin
                e = -int'($urandom_range(1048576));
            end
            r = $urandom_range(99);
            if (r < 15) m = 0;
            else if (r < 20) m = 255;
            else m = $urandom_range(1, 255);
            f = ($urandom_range(99) >= 8);
            add_sample(e, m, f);
        end
    endtask

    // Returns once every queued sample has been sent and every pixel checked.
    task automatic wait_idle();
        do @(posedge i_clk);
        while (sample_q.size() != 0 || s_axis_tvalid || pixel_q.size() != 0);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [ELEV_W-1:0] val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk);
        while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        reg_writes++;
        if (idx == CFG_NODATA_ENABLE) nodata_on = val[0];
        else if (idx == CFG_NODATA_VALUE) nodata_elev = $signed(val);
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings: nodata is off, so a zero sample still gets a color.
        add_sample(0, 1, 1'b1);
        add_sample(-8000, 200, 1'b1);
        add_sample(-8001, 77, 1'b1);
        add_sample(ELEV_MIN, 255, 1'b1);
        add_sample(1, 3, 1'b1);
        add_sample(-4000, 9, 1'b1);
        add_sample(3200, 128, 1'b1);
        add_sample(3201, 64, 1'b1);
        add_sample(9600, 32, 1'b1);
        add_sample(16000, 16, 1'b1);
        add_sample(48000, 8, 1'b1);
        add_sample(96000, 4, 1'b1);
        add_sample(144000, 2, 1'b1);
        add_sample(144001, 170, 1'b1);
        add_sample(ELEV_MAX, 85, 1'b1);
        add_sample(5000, 0, 1'b1);
        add_sample(5000, 255, 1'b0);
        add_sample(-1, 0, 1'b0);
        wait_idle();

        write_reg(CFG_NODATA_ENABLE, 21'd1);
        write_reg(CFG_NODATA_VALUE, 21'd0);
        add_sample(0, 255, 1'b1);
        add_sample(1, 255, 1'b1);
        add_sample(-1, 255, 1'b1);
        add_random(400);
        wait_idle();

        // Out-of-range indexes written after the nodata value must leave nodata alone.
        write_reg(CFG_NODATA_VALUE, 21'h100000);
        write_reg(CFG_SPARE_2, 21'h1FFFFF);
        write_reg(CFG_SPARE_3, 21'h0ABCDE);
        add_sample(ELEV_MIN, 1, 1'b1);
        add_sample(ELEV_MIN + 1, 1, 1'b1);
        add_random(400);
        wait_idle();

        write_reg(CFG_NODATA_VALUE, 21'h0FFFFF);
        add_sample(ELEV_MAX, 255, 1'b1);
        add_random(350);
        wait_idle();

        write_reg(CFG_NODATA_ENABLE, 21'd0);
        write_reg(CFG_NODATA_VALUE, 21'($urandom()));
        add_random(400);
        wait_idle();

        repeat (10) @(posedge i_clk);
        $display("%0d samples streamed: %0d colored pixels, %0d blanked, %0d register writes",
                 samples_sent, pixels_colored, pixels_blank, reg_writes);
        $display("%0d mismatches", mismatches);
        if (mismatches == 0 && pixel_q.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ===== elevation_color_ramp_unit.f =====
rtl/ecr_pkg.sv
rtl/ecr_divide.sv
rtl/elevation_color_ramp_unit.sv
tb/sv/testbench.sv
